// ===== rtl/core/rational_add_sub_reduce_top_defines.svh =====
// Assertion macros for the rational add/sub block.
`ifndef RATIONAL_ADD_SUB_REDUCE_TOP_DEFINES_SVH
`define RATIONAL_ADD_SUB_REDUCE_TOP_DEFINES_SVH

// Implication check on the rising clock edge, off during reset.
`define RAS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check.
`define RAS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ras_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ras_pkg;
  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = 31;
  localparam int unsigned WideW = 64;
  localparam int unsigned CntW = 7;

  typedef enum logic [3:0] {
    StIdle, StMul1, StMul2, StMul3, StSum, StGcdStart, StGcdDiv,
    StGcdNext, StDivNum, StDivDen, StDone
  } ras_state_e;

  // Divider control / status between sequencer and divider.
  typedef struct packed {
    logic start;
  } ras_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ras_div_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/ras_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Registered 32x31 unsigned multiplier.
module ras_mul (
  input  wire logic                        clk_i,
  input  wire logic [ras_pkg::NumW-1:0]    a_i,
  input  wire logic [ras_pkg::DenW-1:0]    b_i,
  output logic      [ras_pkg::WideW-1:0]   p_o
);
  import ras_pkg::*;
  logic [WideW-1:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= WideW'(a_i) * WideW'(b_i);
  end
  assign p_o = p_q;
endmodule
`default_nettype wire

// ===== rtl/core/ras_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module ras_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ras_pkg::ras_div_ctl_t      ctl_i,
  input  wire logic [ras_pkg::WideW-1:0]  dividend_i,
  input  wire logic [ras_pkg::WideW-1:0]  divisor_i,
  output ras_pkg::ras_div_sts_t           sts_o,
  output logic      [ras_pkg::WideW-1:0]  quot_o,
  output logic      [ras_pkg::WideW-1:0]  rem_o
);
  import ras_pkg::*;
  logic [WideW-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WideW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (ctl_i.start) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quot_q[WideW-1]} - {1'b0, dvs_q};
      if (!trial[WideW]) begin
        rem_d  = trial[WideW-1:0];
        quot_d = {quot_q[WideW-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[WideW-2:0], quot_q[WideW-1]};
        quot_d = {quot_q[WideW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WideW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ===== rtl/core/rational_add_sub_reduce_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Adds or subtracts two fractions n1/d1 and n2/d2 and returns the sum or
// difference reduced to lowest terms, sign on the numerator. Zero numerator
// gives 0/1, a zero input denominator gives 0/0. One item at a time: the
// block forms the three products on one registered 32x31 multiplier, then
// runs Euclid's algorithm on a shared 64-bit restoring divider (up to
// roughly 90 remainder steps worst case) and two more divisions for the
// reduction. in_stall_o stays high until the result has been taken;
// out_valid_o holds until out_stall_i is low.
module rational_add_sub_reduce_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        req_type_i,
  input  wire logic signed [31:0]          first_num_i,
  input  wire logic        [30:0]          first_den_i,
  input  wire logic signed [31:0]          second_num_i,
  input  wire logic        [30:0]          second_den_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [63:0]               result_num_o,
  output logic        [62:0]               result_den_o
);
  import ras_pkg::*;
  `include "rational_add_sub_reduce_top_defines.svh"

  ras_state_e state_q, state_d;

  // item operands
  logic             sub_q;
  logic [NumW-1:0]  n1_q, n2_q;
  logic [DenW-1:0]  d1_q, d2_q;
  logic             n1neg, n2neg;
  // products and working values
  logic [WideW-1:0] p_q, p_d, q_q, q_d, den_q, den_d;
  logic [WideW-1:0] mag_q, mag_d, ga_q, ga_d, gb_q, gb_d, g_q, g_d;
  logic             neg_q, neg_d, bad_q, bad_d;
  logic [WideW-1:0] rnum_q, rnum_d;
  logic [WideW-2:0] rden_q, rden_d;

  // multiplier operand selection
  logic [NumW-1:0]  mul_a;
  logic [DenW-1:0]  mul_b;
  logic [WideW-1:0] mul_p;

  // divider
  ras_div_ctl_t     div_ctl;
  ras_div_sts_t     div_sts;
  logic [WideW-1:0] div_a, div_b, div_qt, div_rm;

  logic [WideW-1:0] sp, sq, snum;

  assign n1neg = n1_q[NumW-1];
  assign n2neg = n2_q[NumW-1];

  ras_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ras_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .sts_o      (div_sts),
    .quot_o     (div_qt),
    .rem_o      (div_rm)
  );

  always_comb begin
    state_d = state_q;
    p_d = p_q; q_d = q_q; den_d = den_q;
    mag_d = mag_q; ga_d = ga_q; gb_d = gb_q; g_d = g_q;
    neg_d = neg_q; bad_d = bad_q;
    rnum_d = rnum_q; rden_d = rden_q;
    mul_a = '0; mul_b = '0;
    div_ctl.start = 1'b0;
    div_a = '0; div_b = '0;
    sp = '0; sq = '0; snum = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StMul1;
      end
      StMul1: begin
        // |n1| * d2
        mul_a = n1neg ? (~n1_q + 1'b1) : n1_q;
        mul_b = d2_q;
        bad_d = (d1_q == '0) || (d2_q == '0);
        state_d = StMul2;
      end
      StMul2: begin
        p_d = mul_p;
        mul_a = n2neg ? (~n2_q + 1'b1) : n2_q;
        mul_b = d1_q;
        state_d = StMul3;
      end
      StMul3: begin
        q_d = mul_p;
        mul_a = NumW'(d1_q);
        mul_b = d2_q;
        state_d = StSum;
      end
      StSum: begin
        den_d = mul_p;
        sp = n1neg ? (~p_q + 1'b1) : p_q;
        sq = (n2neg ^ sub_q) ? (~q_q + 1'b1) : q_q;
        snum = sp + sq;
        neg_d = snum[WideW-1];
        mag_d = snum[WideW-1] ? (~snum + 1'b1) : snum;
        if (bad_q) begin
          rnum_d = '0;
          rden_d = '0;
          state_d = StDone;
        end else begin
          ga_d = snum[WideW-1] ? (~snum + 1'b1) : snum;
          gb_d = mul_p;
          state_d = StGcdStart;
        end
      end
      StGcdStart: begin
        if (gb_q == '0) begin
          g_d = ga_q;
          div_ctl.start = 1'b1;
          div_a = mag_q;
          div_b = ga_q;
          state_d = StDivNum;
        end else begin
          div_ctl.start = 1'b1;
          div_a = ga_q;
          div_b = gb_q;
          state_d = StGcdDiv;
        end
      end
      StGcdDiv: begin
        if (div_sts.done) begin
          ga_d = gb_q;
          gb_d = div_rm;
          state_d = StGcdStart;
        end
      end
      StDivNum: begin
        if (div_sts.done) begin
          rnum_d = neg_q ? (~div_qt + 1'b1) : div_qt;
          div_ctl.start = 1'b1;
          div_a = den_q;
          div_b = g_q;
          state_d = StDivDen;
        end
      end
      StDivDen: begin
        if (div_sts.done) begin
          rden_d = div_qt[WideW-2:0];
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      sub_q <= req_type_i;
      n1_q  <= first_num_i;
      d1_q  <= first_den_i;
      n2_q  <= second_num_i;
      d2_q  <= second_den_i;
    end
    p_q <= p_d; q_q <= q_d; den_q <= den_d;
    mag_q <= mag_d; ga_q <= ga_d; gb_q <= gb_d; g_q <= g_d;
    neg_q <= neg_d; bad_q <= bad_d;
    rnum_q <= rnum_d; rden_q <= rden_d;
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = (state_q == StDone);
  assign result_num_o = rnum_q;
  assign result_den_o = rden_q;

  // Divider is only started from the Euclid or reduction states.
  `RAS_ASSERT_IMP(a_start_ctx, clk_i, rst_ni, div_ctl.start,
    (state_q == StGcdStart) || (state_q == StDivNum))
  // A held result keeps its value while stalled.
  `RAS_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(result_num_o) && $stable(result_den_o))
  // No input accepted while a result is pending.
  `RAS_ASSERT_IMP(a_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
endmodule
`default_nettype wire
